[sv/tagged_block_length_deframer_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tagged block length deframer
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAGGED_BLOCK_LENGTH_DEFRAMER_TOP_ASSERT_SVH
`define TAGGED_BLOCK_LENGTH_DEFRAMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tbld_pkg.sv]
// ----------------------------------------------------------------------------
// tbld_pkg
// Widths, codes and phase type of the tagged block length deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbld_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 4;
  localparam int CODE_W   = 4;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 3;
  localparam int LEFT_W   = 3;

  // Header nibble codes
  localparam logic [KIND_W-1:0] KIND_END     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ENTRY_A = 4'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY_B = 4'd10;
  localparam logic [CODE_W-1:0] CODE_DIRECT  = 4'd4;

  // Parsing phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_ENDED
  } phase_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HEAD    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_DATA    = 3'd2,
    ST_END     = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

endpackage

`default_nettype wire

[sv/tagged_block_length_deframer_top.sv]
// ----------------------------------------------------------------------------
// tagged_block_length_deframer_top
// Splits a byte stream into kind-tagged blocks with decoded lengths.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  in_stream_byte
//  out_      output     out_valid/out_stall  status, kind, byte, last, length,
//                                            entry count
//
//  One byte per cycle sustained while out_stall is low; an accepted byte
//  passes through the input register, then the result register.
//  The rate is set by the combinational phase, length and counter update.
//  Reset is synchronous on rst_n.
//  A stalled result holds; the input stage takes one more byte, then
//  in_stall follows out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_block_length_deframer_top (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [tbld_pkg::BYTE_W-1:0]   in_stream_byte,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [tbld_pkg::STATUS_W-1:0] out_status,
  output logic [tbld_pkg::KIND_W-1:0]   out_block_kind,
  output logic [tbld_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic                          out_last_in_block,
  output logic [tbld_pkg::LEN_W-1:0]    out_block_length,
  output logic [tbld_pkg::LEN_W-1:0]    out_entry_count
);

  import tbld_pkg::*;

  // Input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;

  // Parser state
  phase_t            phase_r, phase_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [LEFT_W-1:0] len_left_r, len_left_nxt;
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0]  pay_left_r, pay_left_nxt;
  logic [LEN_W-1:0]  entries_r, entries_nxt;

  // Result stage
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [KIND_W-1:0]   okind_r;
  logic [BYTE_W-1:0]   pay_r;
  logic                last_r;
  logic [LEN_W-1:0]    blen_r;
  logic [LEN_W-1:0]    ocount_r;

  // Result values for the byte in the input stage
  status_t           status_c;
  logic [BYTE_W-1:0] pay_c;
  logic              last_c;
  logic [LEN_W-1:0]  blen_c;

  // Shared decode
  logic              out_free;
  logic              go;
  logic              in_accept;
  logic [KIND_W-1:0] hdr_kind;
  logic [CODE_W-1:0] hdr_code;
  logic              hdr_counted;
  logic [LEN_W-1:0]  direct_len;
  logic [LEN_W-1:0]  acc_shift;
  logic [LEFT_W-1:0] len_left_dec;
  logic [LEN_W-1:0]  pay_left_dec;

  // Handshake: result slot frees when empty or being taken
  assign out_free  = !out_valid_r || !out_stall;
  assign go        = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !out_free);
  assign out_valid_nxt = go || (out_valid_r && out_stall);

  // Decode fields of the staged byte
  assign hdr_kind     = s1_byte_r[KIND_W-1:0];
  assign hdr_code     = s1_byte_r[BYTE_W-1:KIND_W];
  assign direct_len   = LEN_W'(hdr_code - CODE_DIRECT);
  assign acc_shift    = {acc_r[LEN_W-BYTE_W-1:0], s1_byte_r};
  assign len_left_dec = (len_left_r != '0) ? len_left_r - LEFT_W'(1) : len_left_r;
  assign pay_left_dec = (pay_left_r != '0) ? pay_left_r - LEN_W'(1) : pay_left_r;

  always_comb begin
    hdr_counted = 1'b0;
    case (hdr_kind) inside
      KIND_ENTRY_A, KIND_ENTRY_B: hdr_counted = 1'b1;
      default:                    hdr_counted = 1'b0;
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_kind == KIND_END) begin
          phase_nxt = PH_ENDED;
        end else if (hdr_code < CODE_DIRECT) begin
          phase_nxt = PH_LENGTH;
        end else if (direct_len == '0) begin
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_LENGTH: begin
        if (len_left_dec != '0) begin
          phase_nxt = PH_LENGTH;
        end else if (acc_shift == '0) begin
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        phase_nxt = (pay_left_dec == '0) ? PH_HEADER : PH_PAYLOAD;
      end
      PH_ENDED: phase_nxt = PH_ENDED;
      default:  phase_nxt = phase_r;
    endcase
  end

  // Datapath and result values
  always_comb begin
    kind_nxt     = kind_r;
    len_left_nxt = len_left_r;
    acc_nxt      = acc_r;
    pay_left_nxt = pay_left_r;
    entries_nxt  = entries_r;
    status_c     = ST_HEAD;
    pay_c        = '0;
    last_c       = 1'b0;
    blen_c       = '0;
    case (phase_r)
      PH_HEADER: begin
        kind_nxt     = hdr_kind;
        len_left_nxt = '0;
        acc_nxt      = '0;
        pay_left_nxt = '0;
        if (hdr_kind == KIND_END) begin
          status_c = ST_END;
        end else begin
          if (hdr_counted && entries_r != '1) begin
            entries_nxt = entries_r + LEN_W'(1);
          end
          if (hdr_code < CODE_DIRECT) begin
            len_left_nxt = LEFT_W'(hdr_code[1:0]) + LEFT_W'(1);
          end else begin
            acc_nxt      = direct_len;
            pay_left_nxt = direct_len;
            blen_c       = direct_len;
            status_c     = (direct_len == '0) ? ST_EMPTY : ST_HEAD;
          end
        end
      end
      PH_LENGTH: begin
        acc_nxt      = acc_shift;
        len_left_nxt = len_left_dec;
        blen_c       = acc_shift;
        if (len_left_dec == '0) begin
          pay_left_nxt = acc_shift;
          status_c     = (acc_shift == '0) ? ST_EMPTY : ST_HEAD;
        end
      end
      PH_PAYLOAD: begin
        status_c     = ST_DATA;
        pay_c        = s1_byte_r;
        pay_left_nxt = pay_left_dec;
        last_c       = (pay_left_dec == '0);
        blen_c       = acc_r;
      end
      PH_ENDED: status_c = ST_IGNORED;
      default:  status_c = ST_IGNORED;
    endcase
  end

  // Hold or load the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_accept) begin
      s1_byte_r <= in_stream_byte;
    end
  end

  // Advance parser state on each transaction moved to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      kind_r     <= '0;
      len_left_r <= '0;
      acc_r      <= '0;
      pay_left_r <= '0;
      entries_r  <= '0;
    end else if (go) begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      len_left_r <= len_left_nxt;
      acc_r      <= acc_nxt;
      pay_left_r <= pay_left_nxt;
      entries_r  <= entries_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (go) begin
      status_r <= status_c;
      okind_r  <= kind_nxt;
      pay_r    <= pay_c;
      last_r   <= last_c;
      blen_r   <= blen_c;
      ocount_r <= entries_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_block_kind    = okind_r;
  assign out_payload_byte  = pay_r;
  assign out_last_in_block = last_r;
  assign out_block_length  = blen_r;
  assign out_entry_count   = ocount_r;

  // Checks
`include "tagged_block_length_deframer_top_assert.svh"

  `TBLD_ASSERT_NEXT(a_ended_ignores, go && phase_r == PH_ENDED, out_valid_r && status_r == ST_IGNORED, "byte after end marker not reported as ignored")
  `TBLD_ASSERT_SAME(a_payload_nonzero, phase_r == PH_PAYLOAD, pay_left_r != '0, "payload phase with no bytes left")
  `TBLD_ASSERT_NEXT(a_stage_holds, s1_valid_r && !out_free, s1_valid_r && $stable(s1_byte_r), "input stage lost a stalled transaction")
  `TBLD_ASSERT_NEXT(a_entry_step, go && phase_r == PH_HEADER && hdr_kind != KIND_END && hdr_counted && entries_r != '1, entries_r == $past(entries_r) + LEN_W'(1), "entry count did not advance")

endmodule

`default_nettype wire

[dv/tagged_block_length_deframer_checker.sv]
// ----------------------------------------------------------------------------
// tagged_block_length_deframer_checker
// Watches both channels of the deframer, predicts each result from the
// accepted stream bytes, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tagged_block_length_deframer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [tbld_pkg::BYTE_W-1:0]   in_stream_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [tbld_pkg::STATUS_W-1:0] out_status,
  input  logic [tbld_pkg::KIND_W-1:0]   out_block_kind,
  input  logic [tbld_pkg::BYTE_W-1:0]   out_payload_byte,
  input  logic                          out_last_in_block,
  input  logic [tbld_pkg::LEN_W-1:0]    out_block_length,
  input  logic [tbld_pkg::LEN_W-1:0]    out_entry_count,
  output int                            fail_count,
  output int                            pending_count
);

  import tbld_pkg::*;

  typedef struct {
    status_t            status;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [LEN_W-1:0]   blen;
    logic [LEN_W-1:0]   entries;
  } deframe_result_t;

  deframe_result_t expected_results[$];

  // Parser state mirrored from the block
  phase_t             parse_phase;
  logic [KIND_W-1:0]  cur_kind;
  logic [LEFT_W-1:0]  len_bytes_left;
  logic [LEN_W-1:0]   len_acc;
  logic [LEN_W-1:0]   payload_left;
  logic [LEN_W-1:0]   entries_seen;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Latch a decoded length: open the payload or close an empty block.
  task automatic open_payload(input logic [LEN_W-1:0] n, output status_t st);
    len_acc      = n;
    payload_left = n;
    if (n == '0) begin
      parse_phase = PH_HEADER;
      st          = ST_EMPTY;
    end else begin
      parse_phase = PH_PAYLOAD;
      st          = ST_HEAD;
    end
  endtask

  // Advance the parser by one stream byte and build the result it yields.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output deframe_result_t r);
    status_t           st;
    logic [CODE_W-1:0] code;
    st     = ST_HEAD;
    code   = b[BYTE_W-1:KIND_W];
    r.data = '0;
    r.last = 1'b0;
    r.blen = '0;
    case (parse_phase)
      PH_HEADER: begin
        cur_kind       = b[KIND_W-1:0];
        len_acc        = '0;
        payload_left   = '0;
        len_bytes_left = '0;
        if (cur_kind == KIND_END) begin
          parse_phase = PH_ENDED;
          st          = ST_END;
        end else begin
          // count entry blocks on their header, saturating
          if ((cur_kind == KIND_ENTRY_A || cur_kind == KIND_ENTRY_B) &&
              entries_seen != '1)
            entries_seen = entries_seen + LEN_W'(1);
          if (code < CODE_DIRECT) begin
            len_bytes_left = {1'b0, code[1:0]} + 3'd1;
            parse_phase    = PH_LENGTH;
          end else begin
            open_payload(LEN_W'(code - CODE_DIRECT), st);
          end
          r.blen = len_acc;
        end
      end
      PH_LENGTH: begin
        len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
        if (len_bytes_left != '0)
          len_bytes_left = len_bytes_left - LEFT_W'(1);
        if (len_bytes_left == '0)
          open_payload(len_acc, st);
        r.blen = len_acc;
      end
      PH_PAYLOAD: begin
        st     = ST_DATA;
        r.data = b;
        if (payload_left != '0)
          payload_left = payload_left - LEN_W'(1);
        if (payload_left == '0) begin
          r.last      = 1'b1;
          parse_phase = PH_HEADER;
        end
        r.blen = len_acc;
      end
      default: begin
        st = ST_IGNORED;
      end
    endcase
    r.status  = st;
    r.kind    = cur_kind;
    r.entries = entries_seen;
  endtask

  function automatic int field_bad(string fname, logic [LEN_W-1:0] exp_v,
                                   logic [LEN_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Compare retired results, then predict for the byte taken this edge.
  always @(posedge clk) begin
    deframe_result_t want;
    deframe_result_t got;
    int              bad;
    if (!rst_n) begin
      parse_phase    = PH_HEADER;
      cur_kind       = '0;
      len_bytes_left = '0;
      len_acc        = '0;
      payload_left   = '0;
      entries_seen   = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction: status %0h kind %0h byte %0h",
                   $time, out_status, out_block_kind, out_payload_byte);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          bad  = 0;
          bad += field_bad("status", LEN_W'(want.status), LEN_W'(out_status));
          bad += field_bad("block_kind", LEN_W'(want.kind), LEN_W'(out_block_kind));
          bad += field_bad("payload_byte", LEN_W'(want.data), LEN_W'(out_payload_byte));
          bad += field_bad("last_in_block", LEN_W'(want.last), LEN_W'(out_last_in_block));
          bad += field_bad("block_length", want.blen, out_block_length);
          bad += field_bad("entry_count", want.entries, out_entry_count);
          if (bad != 0)
            fail_count = fail_count + 1;
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_stream_byte, got);
        expected_results.insert(expected_results.size(), got);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[dv/tb_tagged_block_length_deframer_top.sv]
// ----------------------------------------------------------------------------
// tb_tagged_block_length_deframer_top
// Drives a dictionary byte stream into the deframer: a directed opening of
// header and length forms, well-formed random blocks under four idle/stall
// mixes, then the end marker and trailing bytes. The checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tagged_block_length_deframer_top;
  import tbld_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1310;
  localparam int NUM_MIXES     = 4;
  localparam int OPENING_LEN   = 23;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_stream_byte = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [KIND_W-1:0]   out_block_kind;
  logic [BYTE_W-1:0]   out_payload_byte;
  logic                out_last_in_block;
  logic [LEN_W-1:0]    out_block_length;
  logic [LEN_W-1:0]    out_entry_count;

  int fail_count;
  int pending_count;
  int stream_items = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int cycle_count  = 0;

  // Empty direct block, one-byte block, every length-code width, empty via
  // length bytes, and extreme byte values.
  logic [BYTE_W-1:0] opening_seq [OPENING_LEN] = '{
    8'h41,
    8'h5A, 8'hFF,
    8'h00, 8'h01, 8'h00,
    8'h0F, 8'h00,
    8'h13, 8'h00, 8'h02, 8'hAA, 8'h55,
    8'h2B, 8'h00, 8'h00, 8'h00,
    8'h3E, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80
  };

  int mix_idle  [NUM_MIXES] = '{0, 87, 0, 14};
  int mix_stall [NUM_MIXES] = '{0, 0, 87, 14};

  tagged_block_length_deframer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_kind    (out_block_kind),
    .out_payload_byte  (out_payload_byte),
    .out_last_in_block (out_last_in_block),
    .out_block_length  (out_block_length),
    .out_entry_count   (out_entry_count)
  );

  tagged_block_length_deframer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_kind    (out_block_kind),
    .out_payload_byte  (out_payload_byte),
    .out_last_in_block (out_last_in_block),
    .out_block_length  (out_block_length),
    .out_entry_count   (out_entry_count),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one byte, idling first at random; return at the next falling edge.
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99, 0) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    stream_items++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been retired.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // Emit one well-formed block with random kind, length form and payload.
  task automatic send_random_block();
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    int unsigned       len;
    int unsigned       pick;
    do kind = KIND_W'($urandom_range(15, 0)); while (kind == KIND_END);
    code = CODE_W'($urandom_range(15, 0));
    push_byte({code, kind});
    if (code >= CODE_DIRECT) begin
      len = code - CODE_DIRECT;
    end else begin
      pick = $urandom_range(9, 0);
      if (pick < 6)
        len = $urandom_range(12, 0);
      else if (pick < 9)
        len = $urandom_range(40, 0);
      else
        len = $urandom_range(300, 0);
      if (code == 0 && len > 255)
        len = 255;
      // big-endian length field, code+1 bytes wide
      for (int i = code; i >= 0; i--)
        push_byte(BYTE_W'(len >> (8 * i)));
    end
    repeat (len) push_byte(BYTE_W'($urandom_range(255, 0)));
  endtask

  initial begin
    int phase_end;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_seq[i])
      push_byte(opening_seq[i]);
    drain_results();

    // Random blocks under each idle/stall mix, fully drained in between
    for (int m = 0; m < NUM_MIXES; m++) begin
      idle_pct  = mix_idle[m];
      stall_pct = mix_stall[m];
      phase_end = stream_items + RANDOM_ITEMS / NUM_MIXES;
      while (stream_items < phase_end)
        send_random_block();
      drain_results();
    end

    // End marker, then bytes that must be ignored
    idle_pct  = 14;
    stall_pct = 14;
    push_byte({CODE_W'($urandom_range(15, 0)), KIND_END});
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hF4);
    push_byte(8'h41);
    repeat (8) push_byte(BYTE_W'($urandom_range(255, 0)));

    drain_results();
    stall_pct = 0;
    repeat (8) @(negedge clk);

    if (fail_count == 0 && pending_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
